// ===== rtl/core/hop_limited_bfs_unreached_count_macros.svh =====
// Assertion macros used by the checker file
`ifndef HOP_LIMITED_BFS_UNREACHED_COUNT_MACROS_SVH
`define HOP_LIMITED_BFS_UNREACHED_COUNT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define HLBFS_AST_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hlbfs check failed");

// Next-cycle implication, disabled during reset
`define HLBFS_AST_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hlbfs check failed");

`endif

// ===== rtl/core/hlbfs_pkg.sv =====
// Shared types and constants for the hop-limited BFS counter
package hlbfs_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int MAX_EDGES    = 4096;
  localparam int VW  = $clog2(MAX_VERTICES);   // vertex number width
  localparam int EAW = $clog2(MAX_EDGES);      // edge store address width
  localparam int CW  = VW + 1;                 // vertex count width
  localparam int ETW = EAW + 1;                // edge total width

  // func codes
  localparam logic [1:0] FUNC_ADD   = 2'd0;
  localparam logic [1:0] FUNC_QUERY = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [1:0]    func;
    logic [VW-1:0] vertex_a;
    logic [VW-1:0] vertex_b;
    logic [VW-1:0] hop_limit;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]    status;
    logic [VW-1:0] unreached_count;
  } out_beat_t;

endpackage

// ===== rtl/core/hlbfs_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module hlbfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/hop_limited_bfs_unreached_count.sv =====
// Hop-limited BFS reachability counter over a stored undirected edge list.
// Add, clear and unused codes: result in the cycle after the beat is taken.
// Query: clear all 1024 visited-map entries, then per popped vertex a fetch
// (pop, queue read, distance read) and a scan of every stored edge, with a
// visit step per edge touching it; the edge memory scan sets the run time.
// rst_n (synchronous) empties the edge store, sets vertex_count to 1024.
module hop_limited_bfs_unreached_count (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  hlbfs_pkg::in_beat_t  in_beat,
  output logic                 out_valid,
  input  logic                 out_stall,
  output hlbfs_pkg::out_beat_t out_beat,
  input  logic                 cfg_we,
  input  logic [hlbfs_pkg::CW-1:0] cfg_wdata
);
  import hlbfs_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLR  = 4'd1;
  localparam logic [3:0] S_INIT = 4'd2;
  localparam logic [3:0] S_POP  = 4'd3;
  localparam logic [3:0] S_POPW = 4'd4;
  localparam logic [3:0] S_DIST = 4'd5;
  localparam logic [3:0] S_EDGE = 4'd6;
  localparam logic [3:0] S_VIS  = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0]     state_r, state_nxt;
  logic [CW-1:0]  vc_r;
  logic [ETW-1:0] etot_r, etot_nxt;
  logic [EAW-1:0] e_r, e_nxt;
  logic [CW-1:0]  head_r, head_nxt, tail_r, tail_nxt, reach_r, reach_nxt;
  logic [VW-1:0]  clr_r, clr_nxt;
  logic [VW-1:0]  src_r, src_nxt, lim_r, lim_nxt;
  logic [VW-1:0]  v_r, v_nxt, w_r, w_nxt, dv_r, dv_nxt;
  logic           out_valid_r, out_valid_nxt;
  out_beat_t      out_r, out_nxt;

  // memory ports
  logic              edge_we;
  logic [EAW-1:0]    edge_waddr;
  logic [2*VW-1:0]   edge_wdata, edge_rdata;
  logic              vis_we;
  logic [VW-1:0]     vis_waddr, vis_raddr;
  logic [VW:0]       vis_wdata, vis_rdata;
  logic              q_we;
  logic [VW-1:0]     q_waddr, q_wdata, q_raddr, q_rdata;

  logic [CW-1:0]  n;
  logic           accept, out_free, last_edge;
  logic [VW-1:0]  ea, eb, dw;

  hlbfs_ram #(.WIDTH(2*VW), .DEPTH(MAX_EDGES)) u_edge (
    .clk, .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
    .raddr(e_nxt), .rdata(edge_rdata)
  );

  hlbfs_ram #(.WIDTH(VW+1), .DEPTH(MAX_VERTICES)) u_vis (
    .clk, .we(vis_we), .waddr(vis_waddr), .wdata(vis_wdata),
    .raddr(vis_raddr), .rdata(vis_rdata)
  );

  hlbfs_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_queue (
    .clk, .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata)
  );

  // effective vertex count
  assign n = (vc_r > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : vc_r;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == S_IDLE) && out_free);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_beat  = out_r;

  assign ea        = edge_rdata[2*VW-1:VW];
  assign eb        = edge_rdata[VW-1:0];
  assign dw        = dv_r + VW'(1);
  assign last_edge = (ETW'(e_r) + ETW'(1)) == etot_r;

  // control and datapath
  always_comb begin
    state_nxt     = state_r;
    etot_nxt      = etot_r;
    e_nxt         = e_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    reach_nxt     = reach_r;
    clr_nxt       = clr_r;
    src_nxt       = src_r;
    lim_nxt       = lim_r;
    v_nxt         = v_r;
    w_nxt         = w_r;
    dv_nxt        = dv_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    edge_we       = 1'b0;
    edge_waddr    = etot_r[EAW-1:0];
    edge_wdata    = {in_beat.vertex_a, in_beat.vertex_b};
    vis_we        = 1'b0;
    vis_waddr     = clr_r;
    vis_wdata     = '0;
    vis_raddr     = w_r;
    q_we          = 1'b0;
    q_waddr       = tail_r[VW-1:0];
    q_wdata       = w_r;
    q_raddr       = head_r[VW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_nxt = '{status: ST_OK, unreached_count: '0};
          case (in_beat.func)
            FUNC_ADD: begin
              out_valid_nxt = 1'b1;
              if (CW'(in_beat.vertex_a) >= n || CW'(in_beat.vertex_b) >= n) begin
                out_nxt.status = ST_RANGE;
              end else if (etot_r == ETW'(MAX_EDGES)) begin
                out_nxt.status = ST_FULL;
              end else begin
                edge_we  = 1'b1;
                etot_nxt = etot_r + ETW'(1);
              end
            end
            FUNC_QUERY: begin
              if (CW'(in_beat.vertex_a) >= n) begin
                out_valid_nxt  = 1'b1;
                out_nxt.status = ST_RANGE;
              end else begin
                src_nxt   = in_beat.vertex_a;
                lim_nxt   = in_beat.hop_limit;
                clr_nxt   = '0;
                state_nxt = S_CLR;
              end
            end
            FUNC_CLEAR: begin
              out_valid_nxt = 1'b1;
              etot_nxt      = '0;
            end
            default: out_valid_nxt = 1'b1;
          endcase
        end
      end
      S_CLR: begin
        vis_we  = 1'b1;
        clr_nxt = clr_r + VW'(1);
        if (clr_r == VW'(MAX_VERTICES - 1)) state_nxt = S_INIT;
      end
      S_INIT: begin
        vis_we    = 1'b1;
        vis_waddr = src_r;
        vis_wdata = {1'b1, VW'(0)};
        q_we      = 1'b1;
        q_waddr   = '0;
        q_wdata   = src_r;
        head_nxt  = '0;
        tail_nxt  = CW'(1);
        reach_nxt = CW'(1);
        state_nxt = S_POP;
      end
      S_POP: begin
        if (head_r == tail_r) begin
          state_nxt = S_DONE;
        end else begin
          head_nxt  = head_r + CW'(1);
          state_nxt = S_POPW;
        end
      end
      S_POPW: begin
        v_nxt     = q_rdata;
        vis_raddr = q_rdata;
        state_nxt = S_DIST;
      end
      S_DIST: begin
        dv_nxt = vis_rdata[VW-1:0];
        if (etot_r == '0) begin
          state_nxt = S_POP;
        end else begin
          e_nxt     = '0;
          state_nxt = S_EDGE;
        end
      end
      S_EDGE: begin
        if (CW'(ea) < n && CW'(eb) < n && (ea == v_r || eb == v_r)) begin
          w_nxt     = (ea == v_r) ? eb : ea;
          vis_raddr = w_nxt;
          state_nxt = S_VIS;
        end else if (last_edge) begin
          state_nxt = S_POP;
        end else begin
          e_nxt = e_r + EAW'(1);
        end
      end
      S_VIS: begin
        if (!vis_rdata[VW]) begin
          vis_we    = 1'b1;
          vis_waddr = w_r;
          vis_wdata = {1'b1, dw};
          q_we      = 1'b1;
          tail_nxt  = tail_r + CW'(1);
          if (dw <= lim_r) reach_nxt = reach_r + CW'(1);
        end
        if (last_edge) begin
          state_nxt = S_POP;
        end else begin
          e_nxt     = e_r + EAW'(1);
          state_nxt = S_EDGE;
        end
      end
      S_DONE: begin
        out_valid_nxt = 1'b1;
        out_nxt       = '{status: ST_OK, unreached_count: VW'(n - reach_r)};
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vc_r        <= CW'(MAX_VERTICES);
      etot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      etot_r      <= etot_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) vc_r <= cfg_wdata;
    end
  end

  // search and payload registers
  always_ff @(posedge clk) begin
    e_r     <= e_nxt;
    head_r  <= head_nxt;
    tail_r  <= tail_nxt;
    reach_r <= reach_nxt;
    clr_r   <= clr_nxt;
    src_r   <= src_nxt;
    lim_r   <= lim_nxt;
    v_r     <= v_nxt;
    w_r     <= w_nxt;
    dv_r    <= dv_nxt;
    out_r   <= out_nxt;
  end

endmodule

// ===== rtl/core/hlbfs_checker.sv =====
// Port-level checks for the hop-limited BFS counter, bound to the top level
`include "hop_limited_bfs_unreached_count_macros.svh"

module hlbfs_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input hlbfs_pkg::in_beat_t  in_beat,
  input logic                 out_valid,
  input logic                 out_stall,
  input hlbfs_pkg::out_beat_t out_beat
);
  import hlbfs_pkg::*;

  // a stalled result beat holds
  `HLBFS_AST_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_beat))
  // no undefined status code
  `HLBFS_AST_IMPL(a_status_code, out_valid, out_beat.status != 2'd3)
  // a failed item reports a zero count
  `HLBFS_AST_IMPL(a_fail_zero, out_valid && out_beat.status != ST_OK,
                  out_beat.unreached_count == '0)
  // an edge add answers in the next cycle
  `HLBFS_AST_NEXT(a_add_next, in_valid && !in_stall && in_beat.func == FUNC_ADD, out_valid)

endmodule

bind hop_limited_bfs_unreached_count hlbfs_checker u_hlbfs_checker (
  .clk, .rst_n, .in_valid, .in_stall, .in_beat, .out_valid, .out_stall, .out_beat
);

// ===== sim/hop_limited_bfs_unreached_count_tb.sv =====
// Testbench for the hop-limited BFS unreached-vertex counter
module hop_limited_bfs_unreached_count_tb;
  import hlbfs_pkg::*;

  typedef enum logic [1:0] {ROW_BEAT, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [1:0]  func;
    int          va;
    int          vb;
    int          lim;
    bit          typed;
    logic [1:0]  status;
    int          count;
  } row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_beat = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_beat;
  logic      cfg_we = 1'b0;
  logic [CW-1:0] cfg_wdata = '0;

  // Shadow of the block state
  int        vcount = 1024;
  int        edge_total = 0;
  int        edge_a [MAX_EDGES];
  int        edge_b [MAX_EDGES];
  out_beat_t pending_results [$];
  int        errors = 0;
  int        snd_pct = 0;
  int        rcv_pct = 0;
  int        group_lo = 0;

  hop_limited_bfs_unreached_count DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_beat(in_beat),
    .out_valid(out_valid), .out_stall(out_stall), .out_beat(out_beat),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // Count of vertices reached within the hop limit from src
  function automatic int reached_within(int src, int lim, int n);
    bit seen [MAX_VERTICES];
    int hop_dist [MAX_VERTICES];
    int fq [MAX_VERTICES];
    int head, tail, reached, v, w;
    head = 0; tail = 0; reached = 1;
    seen[src] = 1'b1;
    hop_dist[src] = 0;
    fq[tail++] = src;
    while (head < tail) begin
      v = fq[head++];
      for (int e = 0; e < edge_total; e++) begin
        // edges left out of range by a lowered count are skipped
        if (edge_a[e] >= n || edge_b[e] >= n) continue;
        if (edge_a[e] == v) w = edge_b[e];
        else if (edge_b[e] == v) w = edge_a[e];
        else continue;
        if (seen[w] || tail >= MAX_VERTICES) continue;
        seen[w] = 1'b1;
        hop_dist[w] = hop_dist[v] + 1;
        fq[tail++] = w;
        if (hop_dist[w] <= lim) reached++;
      end
    end
    return reached;
  endfunction

  // Applies one beat to the shadow state, returns the expected result
  function automatic out_beat_t predict_result(in_beat_t b);
    out_beat_t r;
    int n;
    r = '0;
    n = (vcount > MAX_VERTICES) ? MAX_VERTICES : vcount;
    case (b.func)
      FUNC_ADD: begin
        if (b.vertex_a >= n || b.vertex_b >= n) r.status = ST_RANGE;
        else if (edge_total >= MAX_EDGES) r.status = ST_FULL;
        else begin
          edge_a[edge_total] = b.vertex_a;
          edge_b[edge_total] = b.vertex_b;
          edge_total++;
        end
      end
      FUNC_QUERY: begin
        if (b.vertex_a >= n) r.status = ST_RANGE;
        else r.unreached_count = VW'(n - reached_within(b.vertex_a, b.hop_limit, n));
      end
      FUNC_CLEAR: edge_total = 0;
      default: ;
    endcase
    return r;
  endfunction

  // Drives one beat; returns right after the edge that takes it
  task automatic send_beat(input in_beat_t b, input bit typed, input out_beat_t typed_res);
    out_beat_t r;
    while ($urandom_range(99) < snd_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat <= b;
    forever begin
      @(negedge clk);
      if (!in_stall) break;
    end
    @(posedge clk);
    r = predict_result(b);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  task automatic send(input logic [1:0] f, input int a, input int b2, input int lim);
    in_beat_t b;
    b.func = f; b.vertex_a = VW'(a); b.vertex_b = VW'(b2); b.hop_limit = VW'(lim);
    send_beat(b, 1'b0, '0);
  endtask

  // Holds off until every expected result is back
  task automatic drain;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_vertex_count(input int v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= CW'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    vcount = v;
    @(posedge clk);
  endtask

  function automatic int pick_vertex(int n);
    int span;
    span = (n < 12) ? n : 12;
    return group_lo + $urandom_range(span - 1);
  endfunction

  // One random beat, weighted toward well-formed graph traffic
  task automatic random_beat;
    int n, r;
    n = (vcount > MAX_VERTICES) ? MAX_VERTICES : vcount;
    r = $urandom_range(99);
    if (r < 55) send(FUNC_ADD, pick_vertex(n), pick_vertex(n), 0);
    else if (r < 82)
      send(FUNC_QUERY, pick_vertex(n), 0,
           ($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(6));
    else if (r < 86) send(FUNC_CLEAR, $urandom_range(1023), $urandom_range(1023),
                          $urandom_range(1023));
    else if (r < 90) send(2'd3, $urandom_range(1023), $urandom_range(1023),
                          $urandom_range(1023));
    else send(2'($urandom_range(3)), $urandom_range(1023), $urandom_range(1023),
              $urandom_range(1023));
  endtask

  task automatic random_phase(input int v, input int items);
    int n;
    set_vertex_count(v);
    n = (v > MAX_VERTICES) ? MAX_VERTICES : v;
    group_lo = $urandom_range(n - ((n < 12) ? n : 12));
    send(FUNC_CLEAR, 0, 0, 0);
    repeat (items) random_beat();
  endtask

  // Result checker, sampled mid-cycle ahead of the taking edge
  always @(negedge clk) begin
    out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) report("result beat with nothing expected");
      else begin
        want = pending_results.pop_front();
        if (out_beat.status !== want.status)
          report($sformatf("status %0d, expected %0d", out_beat.status, want.status));
        if (out_beat.unreached_count !== want.unreached_count)
          report($sformatf("unreached_count %0d, expected %0d",
                           out_beat.unreached_count, want.unreached_count));
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rcv_pct);
  end

  initial begin
    row_t      rows [$];
    in_beat_t  b;
    out_beat_t res;
    // directed rows: a typed expectation where it reads off directly
    rows = '{
      '{ROW_BEAT, FUNC_QUERY, 0,    0,    0,    1, ST_OK,    1023},
      '{ROW_BEAT, FUNC_QUERY, 1023, 0,    1023, 1, ST_OK,    1023},
      '{ROW_BEAT, FUNC_ADD,   0,    1023, 0,    1, ST_OK,    0},
      '{ROW_BEAT, FUNC_ADD,   1023, 1023, 0,    1, ST_OK,    0},
      '{ROW_BEAT, FUNC_ADD,   1,    2,    0,    1, ST_OK,    0},
      '{ROW_BEAT, FUNC_ADD,   2,    3,    0,    0, ST_OK,    0},
      '{ROW_BEAT, FUNC_ADD,   3,    4,    0,    0, ST_OK,    0},
      '{ROW_BEAT, FUNC_ADD,   2,    1,    0,    0, ST_OK,    0},
      '{ROW_BEAT, FUNC_QUERY, 1,    0,    0,    1, ST_OK,    1023},
      '{ROW_BEAT, FUNC_QUERY, 1,    1023, 2,    1, ST_OK,    1021},
      '{ROW_BEAT, FUNC_QUERY, 1,    0,    1023, 1, ST_OK,    1020},
      '{ROW_BEAT, FUNC_QUERY, 0,    0,    1,    1, ST_OK,    1022},
      '{ROW_BEAT, 2'd3,       1023, 1023, 1023, 1, ST_OK,    0},
      '{ROW_BEAT, FUNC_CLEAR, 1023, 1023, 1023, 1, ST_OK,    0},
      '{ROW_BEAT, FUNC_QUERY, 0,    0,    1023, 1, ST_OK,    1023},
      '{ROW_BEAT, FUNC_ADD,   5,    900,  0,    0, ST_OK,    0},
      '{ROW_BEAT, FUNC_ADD,   5,    6,    0,    0, ST_OK,    0},
      '{ROW_CFG,  FUNC_ADD,   10,   0,    0,    0, ST_OK,    0},
      '{ROW_BEAT, FUNC_QUERY, 5,    0,    9,    1, ST_OK,    8},
      '{ROW_BEAT, FUNC_ADD,   10,   0,    0,    1, ST_RANGE, 0},
      '{ROW_BEAT, FUNC_ADD,   0,    10,   0,    1, ST_RANGE, 0},
      '{ROW_BEAT, FUNC_QUERY, 10,   0,    0,    1, ST_RANGE, 0},
      '{ROW_CFG,  FUNC_ADD,   0,    0,    0,    0, ST_OK,    0},
      '{ROW_BEAT, FUNC_QUERY, 0,    0,    0,    1, ST_RANGE, 0},
      '{ROW_BEAT, FUNC_ADD,   0,    0,    0,    1, ST_RANGE, 0},
      '{ROW_CFG,  FUNC_ADD,   2047, 0,    0,    0, ST_OK,    0},
      '{ROW_BEAT, FUNC_CLEAR, 0,    0,    0,    1, ST_OK,    0},
      '{ROW_BEAT, FUNC_QUERY, 1023, 0,    0,    1, ST_OK,    1023}
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) set_vertex_count(rows[i].va);
      else begin
        b.func = rows[i].func; b.vertex_a = VW'(rows[i].va);
        b.vertex_b = VW'(rows[i].vb); b.hop_limit = VW'(rows[i].lim);
        res.status = rows[i].status; res.unreached_count = VW'(rows[i].count);
        send_beat(b, rows[i].typed, res);
      end
    end

    // fill the edge store, then overflow it
    set_vertex_count(4);
    send(FUNC_CLEAR, 0, 0, 0);
    while (edge_total < MAX_EDGES) send(FUNC_ADD, $urandom_range(3), $urandom_range(3), 0);
    send(FUNC_ADD, 1, 2, 0);
    send(FUNC_ADD, 4, 0, 0);
    send(FUNC_QUERY, 0, 0, 1023);
    send(FUNC_CLEAR, 0, 0, 0);

    // random traffic under three idling mixes
    snd_pct = 20; rcv_pct = 46;
    random_phase(1, 12);
    random_phase(1024, 20);
    snd_pct = 46; rcv_pct = 20;
    random_phase(1023, 20);
    random_phase(16 + $urandom_range(40), 16);
    snd_pct = 0; rcv_pct = 0;
    random_phase(2, 12);
    random_phase(2047, 20);

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
